// File: hdl/lambertian_hemisphere_sample_top_defines.svh
// ----------------------------------------------------------------------------
// lambertian hemisphere sample assertion macros
// shared check forms for the sampler pipeline
// ----------------------------------------------------------------------------
`ifndef LAMBERTIAN_HEMISPHERE_SAMPLE_TOP_DEFINES_SVH
`define LAMBERTIAN_HEMISPHERE_SAMPLE_TOP_DEFINES_SVH

// same-cycle implication
`define LHS_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lhs assertion failed");

// next-cycle implication
`define LHS_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lhs assertion failed");

`endif

// File: hdl/lhs_pkg.sv
// ----------------------------------------------------------------------------
// lhs_pkg
// constants, register indexes and rounding helper for the hemisphere sampler
// ----------------------------------------------------------------------------
package lhs_pkg;

  localparam int FRAC_BITS = 14;
  localparam int VEC_W     = 16;
  localparam int COL_W     = 16;
  localparam int SZ_W      = 15;
  localparam int DENS_W    = 15;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 3'd3;

  // jitter vector in q(frac_bits)
  localparam longint JIT_X = ((longint'(34) << FRAC_BITS) + 5000) / 10000;
  localparam longint JIT_Y = longint'(1) << FRAC_BITS;
  localparam longint JIT_Z = ((longint'(71) << FRAC_BITS) + 5000) / 10000;

  localparam longint INV_PI_Q32 = 1367130551;
  localparam int     DENS_MAX   = 32767;
  localparam int     DOT_SH     = 2 * FRAC_BITS - 16;

  // arithmetic right shift, rounding half away from zero
  function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] x,
                                                 input int s);
    logic [63:0] h;
    logic [63:0] m;
    h = 64'd1 << (s - 1);
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + h) >> s;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// File: hdl/lhs_unit.sv
// ----------------------------------------------------------------------------
// lhs_unit
// pipelined vector normalize: squares, bitwise square root, restoring divide
// ----------------------------------------------------------------------------
module lhs_unit #(
  parameter int CW = 18,
  parameter int PW = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              i_vld,
  input  logic signed [CW-1:0]              i_c [3],
  input  logic [PW-1:0]                     i_side,
  output logic                              o_vld,
  output logic                              o_ok,
  output logic signed [lhs_pkg::VEC_W-1:0]  o_r [3],
  output logic [PW-1:0]                     o_side
);
  import lhs_pkg::*;

  localparam int LW = 2 * CW;
  localparam int RW = CW;
  localparam int QW = FRAC_BITS + 1;
  localparam int NW = CW + FRAC_BITS + 1;

  // magnitude stage
  logic          a_vld_r;
  logic [CW-1:0] a_mag_r [3];
  logic          a_neg_r [3];
  logic [PW-1:0] a_side_r;

  // square stage
  logic          b_vld_r;
  logic [LW-1:0] b_sq_r [3];
  logic [CW-1:0] b_mag_r [3];
  logic          b_neg_r [3];
  logic [PW-1:0] b_side_r;

  // square root stages
  logic          s_vld_r  [RW+1];
  logic [LW-1:0] s_x_r    [RW+1];
  logic [LW-1:0] s_rt_r   [RW+1];
  logic [CW-1:0] s_mag_r  [RW+1][3];
  logic          s_neg_r  [RW+1][3];
  logic [PW-1:0] s_side_r [RW+1];

  // divide stages
  logic          d_vld_r  [QW+1];
  logic [CW-1:0] d_len_r  [QW+1];
  logic [NW-1:0] d_rem_r  [QW+1][3];
  logic [QW-1:0] d_q_r    [QW+1][3];
  logic          d_neg_r  [QW+1][3];
  logic          d_zero_r [QW+1];
  logic [PW-1:0] d_side_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= 1'b0;
      b_vld_r    <= 1'b0;
      s_vld_r[0] <= 1'b0;
      d_vld_r[0] <= 1'b0;
    end else if (en) begin
      a_vld_r    <= i_vld;
      b_vld_r    <= a_vld_r;
      s_vld_r[0] <= b_vld_r;
      d_vld_r[0] <= s_vld_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_mag_r[i]    <= i_c[i][CW-1] ? CW'(-i_c[i]) : CW'(i_c[i]);
        a_neg_r[i]    <= i_c[i][CW-1];
        b_sq_r[i]     <= LW'(a_mag_r[i]) * LW'(a_mag_r[i]);
        b_mag_r[i]    <= a_mag_r[i];
        b_neg_r[i]    <= a_neg_r[i];
        s_mag_r[0][i] <= b_mag_r[i];
        s_neg_r[0][i] <= b_neg_r[i];
        d_rem_r[0][i] <= (NW'(s_mag_r[RW][i]) << FRAC_BITS) +
                         NW'(s_rt_r[RW][CW-1:0] >> 1);
        d_q_r[0][i]   <= '0;
        d_neg_r[0][i] <= s_neg_r[RW][i];
      end
      a_side_r    <= i_side;
      b_side_r    <= a_side_r;
      s_x_r[0]    <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      s_rt_r[0]   <= '0;
      s_side_r[0] <= b_side_r;
      d_len_r[0]  <= s_rt_r[RW][CW-1:0];
      d_zero_r[0] <= (s_rt_r[RW] == '0);
      d_side_r[0] <= s_side_r[RW];
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam logic [LW-1:0] BK = LW'(1) << (LW - 2 - 2 * k);
    logic [LW-1:0] trial;
    assign trial = s_rt_r[k] + BK;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        s_vld_r[k+1] <= s_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (s_x_r[k] >= trial) begin
          s_x_r[k+1]  <= s_x_r[k] - trial;
          s_rt_r[k+1] <= (s_rt_r[k] >> 1) + BK;
        end else begin
          s_x_r[k+1]  <= s_x_r[k];
          s_rt_r[k+1] <= s_rt_r[k] >> 1;
        end
        s_mag_r[k+1]  <= s_mag_r[k];
        s_neg_r[k+1]  <= s_neg_r[k];
        s_side_r[k+1] <= s_side_r[k];
      end
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NW-1:0] sh;
    assign sh = NW'(d_len_r[k]) << (QW - 1 - k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        d_vld_r[k+1] <= d_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (d_rem_r[k][i] >= sh) begin
            d_rem_r[k+1][i] <= d_rem_r[k][i] - sh;
            d_q_r[k+1][i]   <= d_q_r[k][i] | (QW'(1) << (QW - 1 - k));
          end else begin
            d_rem_r[k+1][i] <= d_rem_r[k][i];
            d_q_r[k+1][i]   <= d_q_r[k][i];
          end
        end
        d_len_r[k+1]  <= d_len_r[k];
        d_neg_r[k+1]  <= d_neg_r[k];
        d_zero_r[k+1] <= d_zero_r[k];
        d_side_r[k+1] <= d_side_r[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_zero_r[QW]) begin
        o_r[i] = '0;
      end else if (d_neg_r[QW][i]) begin
        o_r[i] = -$signed(VEC_W'(d_q_r[QW][i]));
      end else begin
        o_r[i] = $signed(VEC_W'(d_q_r[QW][i]));
      end
    end
  end

  assign o_vld  = d_vld_r[QW];
  assign o_ok   = !d_zero_r[QW];
  assign o_side = d_side_r[QW];

endmodule

// File: hdl/lambertian_hemisphere_sample_top.sv
// one item per cycle while the output is not stalled.
// the two normalize units set the depth: one square-root bit and one
// quotient bit per stage. a stall at the output freezes the whole pipeline.
// reflectance (p_r, rp_r, refl_r) and albedo (p_r, alb_r) track the config regs.
// reset (rst_n low, synchronous) clears the valid bits and config registers.
// ----------------------------------------------------------------------------
// lambertian_hemisphere_sample_top
// cosine-weighted hemisphere direction, pdf, reflectance and albedo
// ----------------------------------------------------------------------------
`include "lambertian_hemisphere_sample_top_defines.svh"

module lambertian_hemisphere_sample_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [lhs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lhs_pkg::COL_W-1:0]             cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lhs_pkg::VEC_W-1:0]      in_normal_x,
  input  logic signed [lhs_pkg::VEC_W-1:0]      in_normal_y,
  input  logic signed [lhs_pkg::VEC_W-1:0]      in_normal_z,
  input  logic signed [lhs_pkg::VEC_W-1:0]      in_sample_x,
  input  logic signed [lhs_pkg::VEC_W-1:0]      in_sample_y,
  input  logic [lhs_pkg::SZ_W-1:0]              in_sample_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lhs_pkg::VEC_W-1:0]      out_dir_x,
  output logic signed [lhs_pkg::VEC_W-1:0]      out_dir_y,
  output logic signed [lhs_pkg::VEC_W-1:0]      out_dir_z,
  output logic [lhs_pkg::DENS_W-1:0]            out_density,
  output logic [lhs_pkg::DENS_W-1:0]            out_refl_red,
  output logic [lhs_pkg::DENS_W-1:0]            out_refl_green,
  output logic [lhs_pkg::DENS_W-1:0]            out_refl_blue,
  output logic [lhs_pkg::COL_W-1:0]             out_albedo_red,
  output logic [lhs_pkg::COL_W-1:0]             out_albedo_green,
  output logic [lhs_pkg::COL_W-1:0]             out_albedo_blue,
  output logic                                  out_degenerate
);
  import lhs_pkg::*;

  localparam int CW1  = 18;
  localparam int CW2  = 22;
  localparam int PW1  = 5 * VEC_W + SZ_W;
  localparam int PW2  = 3 * VEC_W + 1;
  localparam int D16W = 20;
  localparam int DPW  = 52;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- configuration ----------------
  logic [COL_W-1:0] gain_r;
  logic [COL_W-1:0] col_r   [3];
  logic [31:0]      p_r     [3];
  logic [62:0]      rp_r    [3];
  logic [DENS_W-1:0] refl_r [3];
  logic [COL_W-1:0] alb_r   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      col_r  <= '{default: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN:  gain_r   <= cfg_wdata;
        CFG_RED:   col_r[0] <= cfg_wdata;
        CFG_GREEN: col_r[1] <= cfg_wdata;
        CFG_BLUE:  col_r[2] <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_r[i]    <= 32'(gain_r) * 32'(col_r[i]);
      rp_r[i]   <= 63'(p_r[i]) * 63'(INV_PI_Q32);
      refl_r[i] <= DENS_W'((rp_r[i] + (63'(1) << 47)) >> 48);
      alb_r[i]  <= COL_W'((33'(p_r[i]) + 33'h8000) >> 16);
    end
  end

  assign out_refl_red     = refl_r[0];
  assign out_refl_green   = refl_r[1];
  assign out_refl_blue    = refl_r[2];
  assign out_albedo_red   = alb_r[0];
  assign out_albedo_green = alb_r[1];
  assign out_albedo_blue  = alb_r[2];

  // ---------------- frame vector ----------------
  logic                    t1_vld_r, t2_vld_r;
  logic signed [31:0]      t1_raw_r [3];
  logic [PW1-1:0]          t1_side_r, t2_side_r;
  logic signed [CW1-1:0]   t2_red_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_raw_r[0] <= 32'(JIT_Y) * 32'(in_normal_z) - 32'(JIT_Z) * 32'(in_normal_y);
      t1_raw_r[1] <= 32'(JIT_Z) * 32'(in_normal_x) - 32'(JIT_X) * 32'(in_normal_z);
      t1_raw_r[2] <= 32'(JIT_X) * 32'(in_normal_y) - 32'(JIT_Y) * 32'(in_normal_x);
      t1_side_r   <= {in_normal_x, in_normal_y, in_normal_z,
                      in_sample_x, in_sample_y, in_sample_z};
      for (int i = 0; i < 3; i++) begin
        t2_red_r[i] <= CW1'(shr_rnd(64'(t1_raw_r[i]), FRAC_BITS));
      end
      t2_side_r <= t1_side_r;
    end
  end

  logic                     u1_vld, u1_ok;
  logic signed [VEC_W-1:0]  u1_r [3];
  logic [PW1-1:0]           u1_side;

  lhs_unit #(.CW(CW1), .PW(PW1)) u_norm_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .i_vld  (t2_vld_r),
    .i_c    (t2_red_r),
    .i_side (t2_side_r),
    .o_vld  (u1_vld),
    .o_ok   (u1_ok),
    .o_r    (u1_r),
    .o_side (u1_side)
  );

  // ---------------- mapped sample ----------------
  logic                    t3_vld_r, t4_vld_r, t5_vld_r, t6_vld_r, t7_vld_r;
  logic signed [VEC_W-1:0] t3_v_r [3], t4_v_r [3], t5_v_r [3];
  logic signed [VEC_W-1:0] t3_n_r [3], t4_n_r [3], t5_n_r [3], t6_n_r [3], t7_n_r [3];
  logic signed [VEC_W-1:0] t3_s0_r, t3_s1_r, t4_s0_r, t4_s1_r, t5_s0_r, t5_s1_r;
  logic [SZ_W-1:0]         t3_s2_r, t4_s2_r, t5_s2_r;
  logic                    t3_ok_r, t4_ok_r, t5_ok_r, t6_ok_r, t7_ok_r;
  logic signed [31:0]      t4_pv_r [6];
  logic signed [CW1-1:0]   t5_u_r [3];
  logic signed [33:0]      t6_m_r [3][3];
  logic signed [CW2-1:0]   t7_red_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_v_r  <= u1_r;
      t3_ok_r <= u1_ok;
      t3_n_r[0] <= $signed(u1_side[94:79]);
      t3_n_r[1] <= $signed(u1_side[78:63]);
      t3_n_r[2] <= $signed(u1_side[62:47]);
      t3_s0_r   <= $signed(u1_side[46:31]);
      t3_s1_r   <= $signed(u1_side[30:15]);
      t3_s2_r   <= u1_side[14:0];

      t4_pv_r[0] <= 32'(t3_v_r[1]) * 32'(t3_n_r[2]);
      t4_pv_r[1] <= 32'(t3_v_r[2]) * 32'(t3_n_r[1]);
      t4_pv_r[2] <= 32'(t3_v_r[2]) * 32'(t3_n_r[0]);
      t4_pv_r[3] <= 32'(t3_v_r[0]) * 32'(t3_n_r[2]);
      t4_pv_r[4] <= 32'(t3_v_r[0]) * 32'(t3_n_r[1]);
      t4_pv_r[5] <= 32'(t3_v_r[1]) * 32'(t3_n_r[0]);
      t4_v_r  <= t3_v_r;
      t4_n_r  <= t3_n_r;
      t4_s0_r <= t3_s0_r;
      t4_s1_r <= t3_s1_r;
      t4_s2_r <= t3_s2_r;
      t4_ok_r <= t3_ok_r;

      for (int i = 0; i < 3; i++) begin
        t5_u_r[i] <= CW1'(shr_rnd(64'(t4_pv_r[2*i] - t4_pv_r[2*i+1]), FRAC_BITS));
      end
      t5_v_r  <= t4_v_r;
      t5_n_r  <= t4_n_r;
      t5_s0_r <= t4_s0_r;
      t5_s1_r <= t4_s1_r;
      t5_s2_r <= t4_s2_r;
      t5_ok_r <= t4_ok_r;

      for (int i = 0; i < 3; i++) begin
        t6_m_r[i][0] <= 34'(t5_s0_r) * 34'(t5_u_r[i]);
        t6_m_r[i][1] <= 34'(t5_s1_r) * 34'(t5_v_r[i]);
        t6_m_r[i][2] <= $signed({19'd0, t5_s2_r}) * 34'(t5_n_r[i]);
      end
      t6_n_r  <= t5_n_r;
      t6_ok_r <= t5_ok_r;

      for (int i = 0; i < 3; i++) begin
        t7_red_r[i] <= CW2'(shr_rnd(64'(36'(t6_m_r[i][0]) + 36'(t6_m_r[i][1]) +
                                        36'(t6_m_r[i][2])), FRAC_BITS));
      end
      t7_n_r  <= t6_n_r;
      t7_ok_r <= t6_ok_r;
    end
  end

  logic                     u2_vld, u2_ok;
  logic signed [VEC_W-1:0]  u2_r [3];
  logic [PW2-1:0]           u2_side;

  lhs_unit #(.CW(CW2), .PW(PW2)) u_norm_dir (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .i_vld  (t7_vld_r),
    .i_c    (t7_red_r),
    .i_side ({t7_n_r[0], t7_n_r[1], t7_n_r[2], t7_ok_r}),
    .o_vld  (u2_vld),
    .o_ok   (u2_ok),
    .o_r    (u2_r),
    .o_side (u2_side)
  );

  // ---------------- density ----------------
  logic                    t8_vld_r, t9_vld_r, t10_vld_r, t11_vld_r;
  logic signed [VEC_W-1:0] t8_d_r [3], t9_d_r [3], t10_d_r [3], t11_d_r [3];
  logic signed [VEC_W-1:0] t8_n_r [3];
  logic                    t8_ok_r, t9_ok_r, t10_ok_r, t11_ok_r;
  logic signed [31:0]      t9_p_r [3];
  logic signed [33:0]      dot;
  logic [D16W-1:0]         t10_d16_r;
  logic [DPW-1:0]          t11_dp_r;
  logic [DPW-1:0]          dsum;
  logic [D16W-1:0]         dfull;
  logic [DENS_W-1:0]       dens;

  assign dot = 34'(t9_p_r[0]) + 34'(t9_p_r[1]) + 34'(t9_p_r[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      // direction is forced to zero if either normalize met zero length
      for (int i = 0; i < 3; i++) begin
        t8_d_r[i] <= (u2_ok && u2_side[0]) ? u2_r[i] : '0;
      end
      t8_n_r[0] <= $signed(u2_side[48:33]);
      t8_n_r[1] <= $signed(u2_side[32:17]);
      t8_n_r[2] <= $signed(u2_side[16:1]);
      t8_ok_r   <= u2_ok && u2_side[0];

      for (int i = 0; i < 3; i++) begin
        t9_p_r[i] <= 32'(t8_n_r[i]) * 32'(t8_d_r[i]);
      end
      t9_d_r  <= t8_d_r;
      t9_ok_r <= t8_ok_r;

      t10_d16_r <= (dot > 0) ? D16W'(shr_rnd(64'(dot), DOT_SH)) : '0;
      t10_d_r   <= t9_d_r;
      t10_ok_r  <= t9_ok_r;

      t11_dp_r <= DPW'(t10_d16_r) * DPW'(INV_PI_Q32);
      t11_d_r  <= t10_d_r;
      t11_ok_r <= t10_ok_r;
    end
  end

  assign dsum  = t11_dp_r + (DPW'(1) << 31);
  assign dfull = dsum[DPW-1:32];
  assign dens  = (dfull > D16W'(DENS_MAX)) ? DENS_W'(DENS_MAX) : dfull[DENS_W-1:0];

  // ---------------- valid chain and output register ----------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r    <= 1'b0;
      t2_vld_r    <= 1'b0;
      t3_vld_r    <= 1'b0;
      t4_vld_r    <= 1'b0;
      t5_vld_r    <= 1'b0;
      t6_vld_r    <= 1'b0;
      t7_vld_r    <= 1'b0;
      t8_vld_r    <= 1'b0;
      t9_vld_r    <= 1'b0;
      t10_vld_r   <= 1'b0;
      t11_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      t1_vld_r    <= in_valid;
      t2_vld_r    <= t1_vld_r;
      t3_vld_r    <= u1_vld;
      t4_vld_r    <= t3_vld_r;
      t5_vld_r    <= t4_vld_r;
      t6_vld_r    <= t5_vld_r;
      t7_vld_r    <= t6_vld_r;
      t8_vld_r    <= u2_vld;
      t9_vld_r    <= t8_vld_r;
      t10_vld_r   <= t9_vld_r;
      t11_vld_r   <= t10_vld_r;
      out_valid_r <= t11_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dir_x      <= t11_d_r[0];
      out_dir_y      <= t11_d_r[1];
      out_dir_z      <= t11_d_r[2];
      out_density    <= t11_ok_r ? dens : '0;
      out_degenerate <= !t11_ok_r;
    end
  end

  assign out_valid = out_valid_r;

  `LHS_ASSERT_IMP(a_stall_src, in_stall, out_valid && out_stall)
  `LHS_ASSERT_IMP(a_degen_zero, out_valid && out_degenerate, out_dir_x == 0 && out_dir_y == 0 && out_dir_z == 0 && out_density == 0)
  `LHS_ASSERT_IMP(a_dir_range, out_valid, out_dir_x <= 16384 && out_dir_x >= -16384 && out_dir_z <= 16384 && out_dir_z >= -16384)
  `LHS_ASSERT_NXT(a_drain, out_valid && !out_stall && !t11_vld_r, !out_valid)

endmodule
